// ===== rtl/core/qse_pkg.sv =====
// qse_pkg: types, constants and handshake structs of the quadrature speed estimator
// used by qse_divider, qse_mac and quadrature_speed_estimator; no dependencies

package qse_pkg;

   localparam int DIVIDEND_W = 42;
   localparam int DIVISOR_W  = 32;
   localparam int COEF_W     = 16;
   localparam int SPEED_W    = 48;
   localparam int COUNT_W    = 32;
   localparam int TIME_W     = 32;
   localparam int RATE_W     = 21;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [DIVIDEND_W-1:0] RATE_NUMERATOR = DIVIDEND_W'(1000000);

   localparam logic [COEF_W-1:0] CPR_RESET   = 16'd1024;
   localparam logic [TIME_W-1:0] STALL_RESET = 32'd153846;
   localparam logic [COEF_W-1:0] POLE_RESET  = 16'd55968;
   localparam logic [COEF_W-1:0] ZERO_RESET  = 16'd4771;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNTS_PER_REV = 8'd0,
      CSR_STALL_TIMEOUT  = 8'd1,
      CSR_POLE_COEF      = 8'd2,
      CSR_ZERO_COEF      = 8'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ELAPSED,
      ST_EDGE,
      ST_DIV_RATE,
      ST_STALL,
      ST_SCALE,
      ST_DIV_RPM,
      ST_F1_GO,
      ST_F1_WAIT,
      ST_F2_GO,
      ST_F2_WAIT,
      ST_F3_GO,
      ST_F3_WAIT,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      STEP_NONE,
      STEP_UP,
      STEP_DOWN
   } step_dir_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                      start;
      logic signed [SPEED_W-1:0] fb;
      logic signed [SPEED_W-1:0] x;
      logic signed [SPEED_W-1:0] x_prev;
      logic [COEF_W-1:0]         pole;
      logic [COEF_W-1:0]         zero;
   } mac_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [SPEED_W-1:0] result;
   } mac_rsp_type;

endpackage

// ===== rtl/core/qse_divider.sv =====
// qse_divider: restoring unsigned divider, one quotient bit per cycle
// depends on qse_pkg for widths and the request/response structs

module qse_divider (
   input  logic                clock,
   input  logic                reset,
   input  qse_pkg::div_req_type div_req,
   output qse_pkg::div_rsp_type div_rsp
);
   import qse_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  dvsr_ff, dvsr_in;

   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W+1:0] diff;
   logic                 fits;

   assign shifted = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvsr_ff};
   assign fits    = ~diff[DIVISOR_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvsr_in = dvsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quot_in = div_req.dividend;
         dvsr_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

// ===== rtl/core/qse_mac.sv =====
// qse_mac: filter stage, floor((fb*pole + x*zero + x_prev*zero) / 2^16) saturated to 48 bits
// one 25x17 multiply per cycle over six half-word partial products; depends on qse_pkg

module qse_mac (
   input  logic                clock,
   input  logic                reset,
   input  qse_pkg::mac_req_type mac_req,
   output qse_pkg::mac_rsp_type mac_rsp
);
   import qse_pkg::*;

   localparam int HALF_W  = SPEED_W / 2;
   localparam int MUL_A_W = HALF_W + 1;
   localparam int MUL_B_W = COEF_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = SPEED_W + COEF_W + 4;
   localparam int TOP_W   = ACC_W - (SPEED_W + COEF_W - 1);
   localparam logic [2:0] LAST_PROD = 3'd5;
   localparam logic [2:0] LAST_ACC  = 3'd6;
   localparam logic [2:0] FINISH    = 3'd7;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [2:0]                phase_ff, phase_in;
   logic signed [SPEED_W-1:0] fb_ff, fb_in;
   logic signed [SPEED_W-1:0] x_ff, x_in;
   logic signed [SPEED_W-1:0] xp_ff, xp_in;
   logic [COEF_W-1:0]         pole_ff, pole_in;
   logic [COEF_W-1:0]         zero_ff, zero_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic                      prod_hi_ff, prod_hi_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [SPEED_W-1:0] result_ff, result_in;

   logic [SPEED_W-1:0]        operand;
   logic [COEF_W-1:0]         coef;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [ACC_W-1:0]   prod_ext;
   logic [TOP_W-1:0]          acc_top;

   always_comb begin
      case (phase_ff[2:1])
         2'd0: begin
            operand = fb_ff;
            coef    = pole_ff;
         end
         2'd1: begin
            operand = x_ff;
            coef    = zero_ff;
         end
         2'd2: begin
            operand = xp_ff;
            coef    = zero_ff;
         end
         default: begin
            operand = '0;
            coef    = '0;
         end
      endcase
      mul_a = phase_ff[0] ? {operand[SPEED_W-1], operand[SPEED_W-1:HALF_W]}
                          : {1'b0, operand[HALF_W-1:0]};
      mul_b = {1'b0, coef};
   end

   always_comb begin
      prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (prod_hi_ff) begin
         prod_ext = {prod_ext[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
      end
   end

   assign acc_top = acc_ff[ACC_W-1:SPEED_W+COEF_W-1];

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      phase_in   = phase_ff;
      fb_in      = fb_ff;
      x_in       = x_ff;
      xp_in      = xp_ff;
      pole_in    = pole_ff;
      zero_in    = zero_ff;
      prod_in    = prod_ff;
      prod_hi_in = prod_hi_ff;
      acc_in     = acc_ff;
      result_in  = result_ff;
      if (mac_req.start) begin
         busy_in  = 1'b1;
         phase_in = '0;
         fb_in    = mac_req.fb;
         x_in     = mac_req.x;
         xp_in    = mac_req.x_prev;
         pole_in  = mac_req.pole;
         zero_in  = mac_req.zero;
         acc_in   = '0;
      end else if (busy_ff) begin
         phase_in = phase_ff + 3'd1;
         if (phase_ff <= LAST_PROD) begin
            prod_in    = mul_a * mul_b;
            prod_hi_in = phase_ff[0];
         end
         if (phase_ff != 3'd0 && phase_ff <= LAST_ACC) begin
            acc_in = acc_ff + prod_ext;
         end
         if (phase_ff == FINISH) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (acc_top == '0 || acc_top == '1) begin
               result_in = acc_ff[SPEED_W+COEF_W-1:COEF_W];
            end else if (acc_ff[ACC_W-1]) begin
               result_in = {1'b1, {(SPEED_W-1){1'b0}}};
            end else begin
               result_in = {1'b0, {(SPEED_W-1){1'b1}}};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      fb_ff      <= fb_in;
      x_ff       <= x_in;
      xp_ff      <= xp_in;
      pole_ff    <= pole_in;
      zero_ff    <= zero_in;
      prod_ff    <= prod_in;
      prod_hi_ff <= prod_hi_in;
      acc_ff     <= acc_in;
      result_ff  <= result_in;
   end

   assign mac_rsp.done   = done_ff;
   assign mac_rsp.result = result_ff;

endmodule

// ===== rtl/core/quadrature_speed_estimator.sv =====
// quadrature_speed_estimator: quadrature decode, period velocity and three-stage rpm filter
// an edge beat runs elapsed time, decode and the rate divide; a tick beat runs elapsed
// time, stall check, scaling, the rpm divide and three filter passes; both divides use
// the 42-step serial divider; one beat in work at a time, taken while the last result waits
// synchronous active-high reset clears position, timing, rate and filter state
// and loads the register defaults; depends on qse_pkg, qse_divider and qse_mac

module quadrature_speed_estimator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [39:0]                       req_tdata,  // pin_a, pin_b, time_us[31:0]
   input  logic                              req_tuser,  // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // position_count[31:0], filtered_rpm[47:0], edge_rate[20:0]
   output logic [103:0]                      rsp_tdata,
   output logic                              rsp_tuser,  // bad_transition
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qse_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qse_pkg::CSR_DATA_W-1:0]    csr_data
);
   import qse_pkg::*;

   localparam int RSP_W = 104;
   localparam logic signed [RATE_W-1:0] RATE_MAX = 21'sd1000000;

   state_type state_ff, state_in;

   logic                      op_ff, op_in;
   logic [1:0]                pins_ff, pins_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic [1:0]                last_pins_ff, last_pins_in;
   logic signed [COUNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]         last_edge_ff, last_edge_in;
   logic [TIME_W-1:0]         elapsed_ff, elapsed_in;
   logic signed [RATE_W-1:0]  edge_rate_ff, edge_rate_in;
   step_dir_type              step_ff, step_in;
   logic                      bad_ff, bad_in;
   logic signed [SPEED_W-1:0] raw_ff, raw_in;
   logic signed [SPEED_W-1:0] prev_raw_ff, prev_raw_in;
   logic signed [SPEED_W-1:0] stage_one_ff, stage_one_in;
   logic signed [SPEED_W-1:0] prev_stage_one_ff, prev_stage_one_in;
   logic signed [SPEED_W-1:0] stage_two_ff, stage_two_in;
   logic signed [SPEED_W-1:0] prev_stage_two_ff, prev_stage_two_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic [COEF_W-1:0]         cpr_ff, cpr_in;
   logic [TIME_W-1:0]         stall_ff, stall_in;
   logic [COEF_W-1:0]         pole_ff, pole_in;
   logic [COEF_W-1:0]         zero_ff, zero_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;
   logic                      rsp_user_ff, rsp_user_in;

   logic        req_accept;
   logic        rsp_load;
   div_req_type div_req;
   div_rsp_type div_rsp;
   mac_req_type mac_req;
   mac_rsp_type mac_rsp;

   logic [RATE_W-1:0]         abs_rate;
   logic [25:0]               mag60;
   logic signed [RATE_W-1:0]  q_rate;
   logic signed [SPEED_W-1:0] q_speed;

   function automatic step_dir_type decode_step(input logic [3:0] code);
      step_dir_type dir;
      case (code) inside
         4'b1101, 4'b0100, 4'b0010, 4'b1011: dir = STEP_UP;
         4'b1110, 4'b0111, 4'b0001, 4'b1000: dir = STEP_DOWN;
         default:                            dir = STEP_NONE;
      endcase
      return dir;
   endfunction

   qse_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   qse_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_req (mac_req),
      .mac_rsp (mac_rsp)
   );

   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign abs_rate = edge_rate_ff[RATE_W-1] ? RATE_W'(-edge_rate_ff) : edge_rate_ff;
   assign mag60    = {abs_rate[19:0], 6'b0} - {4'b0, abs_rate[19:0], 2'b0};
   assign q_rate   = div_rsp.quotient[RATE_W-1:0];
   assign q_speed  = {{(SPEED_W-DIVIDEND_W){1'b0}}, div_rsp.quotient};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_accept) state_in = ST_ELAPSED;
         ST_ELAPSED:  state_in = (op_ff == OP_TICK) ? ST_STALL : ST_EDGE;
         ST_EDGE:     state_in = ST_DIV_RATE;
         ST_DIV_RATE: if (div_rsp.done) state_in = ST_RESULT;
         ST_STALL:    state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_DIV_RPM;
         ST_DIV_RPM:  if (div_rsp.done) state_in = ST_F1_GO;
         ST_F1_GO:    state_in = ST_F1_WAIT;
         ST_F1_WAIT:  if (mac_rsp.done) state_in = ST_F2_GO;
         ST_F2_GO:    state_in = ST_F2_WAIT;
         ST_F2_WAIT:  if (mac_rsp.done) state_in = ST_F3_GO;
         ST_F3_GO:    state_in = ST_F3_WAIT;
         ST_F3_WAIT:  if (mac_rsp.done) state_in = ST_RESULT;
         ST_RESULT:   if (rsp_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready       = 1'b0;
      rsp_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = RATE_NUMERATOR;
      div_req.divisor  = (elapsed_ff == '0) ? DIVISOR_W'(1) : elapsed_ff;
      mac_req.start    = 1'b0;
      mac_req.fb       = stage_one_ff;
      mac_req.x        = raw_ff;
      mac_req.x_prev   = prev_raw_ff;
      mac_req.pole     = pole_ff;
      mac_req.zero     = zero_ff;
      unique case (state_ff) inside
         ST_IDLE: req_tready = 1'b1;
         ST_EDGE: div_req.start = 1'b1;
         ST_SCALE: begin
            div_req.start    = 1'b1;
            div_req.dividend = {mag60, {COEF_W{1'b0}}};
            div_req.divisor  = {{(DIVISOR_W-COEF_W){1'b0}},
                                (cpr_ff == '0) ? COEF_W'(1) : cpr_ff};
         end
         ST_F1_GO: mac_req.start = 1'b1;
         ST_F2_GO, ST_F2_WAIT: begin
            mac_req.start  = (state_ff == ST_F2_GO);
            mac_req.fb     = stage_two_ff;
            mac_req.x      = stage_one_ff;
            mac_req.x_prev = prev_stage_one_ff;
         end
         ST_F3_GO, ST_F3_WAIT: begin
            mac_req.start  = (state_ff == ST_F3_GO);
            mac_req.fb     = speed_ff;
            mac_req.x      = stage_two_ff;
            mac_req.x_prev = prev_stage_two_ff;
         end
         ST_RESULT: rsp_load = ~rsp_valid_ff | rsp_tready;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      op_in             = op_ff;
      pins_in           = pins_ff;
      time_in           = time_ff;
      last_pins_in      = last_pins_ff;
      count_in          = count_ff;
      last_edge_in      = last_edge_ff;
      elapsed_in        = elapsed_ff;
      edge_rate_in      = edge_rate_ff;
      step_in           = step_ff;
      bad_in            = bad_ff;
      raw_in            = raw_ff;
      prev_raw_in       = prev_raw_ff;
      stage_one_in      = stage_one_ff;
      prev_stage_one_in = prev_stage_one_ff;
      stage_two_in      = stage_two_ff;
      prev_stage_two_in = prev_stage_two_ff;
      speed_in          = speed_ff;
      rsp_data_in       = rsp_data_ff;
      rsp_user_in       = rsp_user_ff;

      if (req_accept) begin
         op_in   = req_tuser;
         pins_in = {req_tdata[0], req_tdata[1]};
         time_in = req_tdata[TIME_W+1:2];
         bad_in  = 1'b0;
      end

      unique case (state_ff)
         ST_ELAPSED: elapsed_in = time_ff - last_edge_ff;
         ST_EDGE: begin
            step_in      = decode_step({last_pins_ff, pins_ff});
            bad_in       = (step_in == STEP_NONE);
            last_pins_in = pins_ff;
            last_edge_in = time_ff;
            if (step_in == STEP_UP) begin
               count_in = count_ff + 32'sd1;
            end else if (step_in == STEP_DOWN) begin
               count_in = count_ff - 32'sd1;
            end
         end
         ST_DIV_RATE: begin
            if (div_rsp.done) begin
               unique case (step_ff)
                  STEP_UP:   edge_rate_in = q_rate;
                  STEP_DOWN: edge_rate_in = -q_rate;
                  default:   edge_rate_in = '0;
               endcase
            end
         end
         ST_STALL: if (elapsed_ff > stall_ff) edge_rate_in = '0;
         ST_DIV_RPM: begin
            if (div_rsp.done) begin
               raw_in = edge_rate_ff[RATE_W-1] ? -q_speed : q_speed;
            end
         end
         ST_F1_WAIT: if (mac_rsp.done) stage_one_in = mac_rsp.result;
         ST_F2_WAIT: if (mac_rsp.done) stage_two_in = mac_rsp.result;
         ST_F3_WAIT: begin
            if (mac_rsp.done) begin
               speed_in          = mac_rsp.result;
               prev_raw_in       = raw_ff;
               prev_stage_one_in = stage_one_ff;
               prev_stage_two_in = stage_two_ff;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_data_in = {3'b000, edge_rate_ff, speed_ff, count_ff};
               rsp_user_in = bad_ff;
            end
         end
         default: ;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register file
   always_comb begin
      cpr_in   = cpr_ff;
      stall_in = stall_ff;
      pole_in  = pole_ff;
      zero_in  = zero_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COUNTS_PER_REV: cpr_in   = csr_data[COEF_W-1:0];
            CSR_STALL_TIMEOUT:  stall_in = csr_data[TIME_W-1:0];
            CSR_POLE_COEF:      pole_in  = csr_data[COEF_W-1:0];
            CSR_ZERO_COEF:      zero_in  = csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         last_pins_ff      <= '0;
         count_ff          <= '0;
         last_edge_ff      <= '0;
         edge_rate_ff      <= '0;
         prev_raw_ff       <= '0;
         stage_one_ff      <= '0;
         prev_stage_one_ff <= '0;
         stage_two_ff      <= '0;
         prev_stage_two_ff <= '0;
         speed_ff          <= '0;
         cpr_ff            <= CPR_RESET;
         stall_ff          <= STALL_RESET;
         pole_ff           <= POLE_RESET;
         zero_ff           <= ZERO_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         last_pins_ff      <= last_pins_in;
         count_ff          <= count_in;
         last_edge_ff      <= last_edge_in;
         edge_rate_ff      <= edge_rate_in;
         prev_raw_ff       <= prev_raw_in;
         stage_one_ff      <= stage_one_in;
         prev_stage_one_ff <= prev_stage_one_in;
         stage_two_ff      <= stage_two_in;
         prev_stage_two_ff <= prev_stage_two_in;
         speed_ff          <= speed_in;
         cpr_ff            <= cpr_in;
         stall_ff          <= stall_in;
         pole_ff           <= pole_in;
         zero_ff           <= zero_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      op_ff       <= op_in;
      pins_ff     <= pins_in;
      time_ff     <= time_in;
      elapsed_ff  <= elapsed_in;
      step_ff     <= step_in;
      bad_ff      <= bad_in;
      raw_ff      <= raw_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV_RATE || state_ff == ST_DIV_RPM))
      else $error("divider finished outside a divide wait state");

   a_mac_done_waited: assert property (@(posedge clock) disable iff (reset)
      mac_rsp.done |-> (state_ff == ST_F1_WAIT || state_ff == ST_F2_WAIT ||
                        state_ff == ST_F3_WAIT))
      else $error("filter stage finished outside a filter wait state");

   a_count_only_on_edge: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(state_ff) == ST_EDGE))
      else $error("position count moved outside edge decode");

   a_rate_bounded: assert property (@(posedge clock) disable iff (reset)
      (edge_rate_ff <= RATE_MAX) && (edge_rate_ff >= -RATE_MAX))
      else $error("edge rate out of range");

   a_one_beat_in_work: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("second beat taken while one is in work");

endmodule

// ===== tb/sv/qse_checker.sv =====
// qse_checker: watches the request, result and register channels of the quadrature speed
// estimator, predicts every result beat and compares it field by field with the block
// depends on qse_pkg for the op and register index codes and the step direction type

module qse_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [39:0]                    req_tdata,  // pin_a, pin_b, time_us[31:0]
   input  logic                           req_tuser,  // op
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // position_count[31:0], filtered_rpm[47:0], edge_rate[20:0]
   input  logic [103:0]                   rsp_tdata,
   input  logic                           rsp_tuser,  // bad_transition
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [qse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qse_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             mismatch_count,
   output int                             result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic signed [79:0] SPEED_MAX = 80'sh7FFF_FFFF_FFFF;
   localparam logic signed [79:0] SPEED_MIN = -SPEED_MAX - 80'sd1;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [47:0] rpm;
      logic signed [20:0] rate;
      logic               bad;
   } speed_result_type;

   speed_result_type expected_results[$];

   logic [15:0] cpr_cfg;
   logic [31:0] stall_cfg;
   logic [15:0] pole_cfg;
   logic [15:0] zero_cfg;

   logic [1:0]         last_pins;
   logic [31:0]        position_q;
   logic [31:0]        last_edge_us;
   logic signed [20:0] edge_rate_q;
   logic signed [47:0] raw_prev;
   logic signed [47:0] stage1;
   logic signed [47:0] stage1_prev;
   logic signed [47:0] stage2;
   logic signed [47:0] stage2_prev;
   logic signed [47:0] speed_q;

   function automatic logic signed [47:0] filter_stage(logic signed [47:0] fb,
                                                       logic signed [47:0] x,
                                                       logic signed [47:0] xp,
                                                       logic [15:0] pole,
                                                       logic [15:0] zero);
      logic signed [79:0] acc;
      logic signed [16:0] p;
      logic signed [16:0] z;
      p = {1'b0, pole};
      z = {1'b0, zero};
      acc = fb * p + x * z + xp * z;
      acc = acc >>> 16;
      if (acc > SPEED_MAX) acc = SPEED_MAX;
      if (acc < SPEED_MIN) acc = SPEED_MIN;
      return acc[47:0];
   endfunction

   function automatic speed_result_type predict_beat(logic op, logic pin_a, logic pin_b,
                                                     logic [31:0] now);
      speed_result_type res;
      logic [31:0] elapsed;
      logic [31:0] mag;
      logic [3:0] code;
      qse_pkg::step_dir_type dir;
      longint r;
      longint raw;
      longint unsigned rmag;
      longint unsigned cpr;
      elapsed = now - last_edge_us;
      res.bad = 1'b0;
      if (op == qse_pkg::OP_EDGE) begin
         code = {last_pins, pin_a, pin_b};
         case (code)
            4'd13, 4'd4, 4'd2, 4'd11: dir = qse_pkg::STEP_UP;
            4'd14, 4'd7, 4'd1, 4'd8: dir = qse_pkg::STEP_DOWN;
            default: dir = qse_pkg::STEP_NONE;
         endcase
         if (dir == qse_pkg::STEP_NONE) res.bad = 1'b1;
         if (dir == qse_pkg::STEP_UP) position_q = position_q + 32'd1;
         if (dir == qse_pkg::STEP_DOWN) position_q = position_q - 32'd1;
         last_pins = {pin_a, pin_b};
         if (elapsed == 32'd0) elapsed = 32'd1;
         mag = 32'd1000000 / elapsed;
         case (dir)
            qse_pkg::STEP_UP: edge_rate_q = mag[20:0];
            qse_pkg::STEP_DOWN: edge_rate_q = -$signed(mag[20:0]);
            default: edge_rate_q = '0;
         endcase
         last_edge_us = now;
      end else begin
         cpr = (cpr_cfg == 16'd0) ? 64'd1 : 64'(cpr_cfg);
         if (elapsed > stall_cfg) edge_rate_q = '0;
         r = longint'(edge_rate_q);
         rmag = (r < 0) ? longint'(-r) : longint'(r);
         rmag = (rmag * 64'd60 * 64'd65536) / cpr;
         raw = (r < 0) ? -longint'(rmag) : longint'(rmag);
         stage1 = filter_stage(stage1, raw[47:0], raw_prev, pole_cfg, zero_cfg);
         stage2 = filter_stage(stage2, stage1, stage1_prev, pole_cfg, zero_cfg);
         speed_q = filter_stage(speed_q, stage2, stage2_prev, pole_cfg, zero_cfg);
         raw_prev = raw[47:0];
         stage1_prev = stage1;
         stage2_prev = stage2;
      end
      res.position = position_q;
      res.rpm = speed_q;
      res.rate = edge_rate_q;
      return res;
   endfunction

   always @(posedge clock) begin
      speed_result_type want;
      speed_result_type got;
      if (reset) begin
         mismatch_count <= 0;
         result_count <= 0;
         cpr_cfg = qse_pkg::CPR_RESET;
         stall_cfg = qse_pkg::STALL_RESET;
         pole_cfg = qse_pkg::POLE_RESET;
         zero_cfg = qse_pkg::ZERO_RESET;
         last_pins = '0;
         position_q = '0;
         last_edge_us = '0;
         edge_rate_q = '0;
         raw_prev = '0;
         stage1 = '0;
         stage1_prev = '0;
         stage2 = '0;
         stage2_prev = '0;
         speed_q = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (qse_pkg::csr_index_type'(csr_index))
               qse_pkg::CSR_COUNTS_PER_REV: cpr_cfg = csr_data[15:0];
               qse_pkg::CSR_STALL_TIMEOUT: stall_cfg = csr_data;
               qse_pkg::CSR_POLE_COEF: pole_cfg = csr_data[15:0];
               qse_pkg::CSR_ZERO_COEF: zero_cfg = csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            got.position = rsp_tdata[31:0];
            got.rpm = rsp_tdata[79:32];
            got.rate = rsp_tdata[100:80];
            got.bad = rsp_tuser;
            if (expected_results.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("result beat with nothing expected: position %0d rpm %0d rate %0d",
                           got.position, got.rpm, got.rate);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.position !== got.position || want.rpm !== got.rpm ||
                   want.rate !== got.rate || want.bad !== got.bad) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("beat %0d: position %0d/%0d rpm %0d/%0d rate %0d/%0d bad %0b/%0b",
                              result_count, want.position, got.position, want.rpm, got.rpm,
                              want.rate, got.rate, want.bad, got.bad);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_beat(req_tuser, req_tdata[0], req_tdata[1],
                                                    req_tdata[33:2]));
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: clock, reset and stimulus for the quadrature speed estimator, with the verdict
// drives edge and tick beats and register writes; depends on qse_pkg, qse_checker and the block

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int SEG_BEATS = 275;
   localparam int TAIL_CYCLES = 200;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [39:0]                    req_tdata = '0;  // pin_a, pin_b, time_us[31:0]
   logic                           req_tuser = 1'b0;  // op
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   // position_count[31:0], filtered_rpm[47:0], edge_rate[20:0]
   logic [103:0]                   rsp_tdata;
   logic                           rsp_tuser;  // bad_transition
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [qse_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [qse_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int mismatch_count;
   int result_count;
   int send_idle_pct = 9;
   int recv_idle_pct = 63;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int beats_sent = 0;

   logic [1:0] gray_seq [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

   quadrature_speed_estimator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   qse_checker u_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .mismatch_count(mismatch_count), .result_count(result_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_served + 1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic offer_beat(input logic op, input logic pin_a, input logic pin_b,
                             input logic [31:0] us);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         if ($urandom_range(19) == 0)
            repeat ($urandom_range(1, 100)) @(posedge clock);
         else
            do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'b0, us, pin_b, pin_a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (result_count != beats_sent) @(posedge clock);
   endtask

   task automatic write_reg(input qse_pkg::csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] cpr, input logic [31:0] stall,
                               input logic [31:0] pole, input logic [31:0] zero);
      write_reg(qse_pkg::CSR_COUNTS_PER_REV, cpr);
      write_reg(qse_pkg::CSR_STALL_TIMEOUT, stall);
      write_reg(qse_pkg::CSR_POLE_COEF, pole);
      write_reg(qse_pkg::CSR_ZERO_COEF, zero);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [31:0] now_us;
      logic [31:0] delta;
      logic [1:0] pins;
      logic noise_a;
      logic noise_b;
      int gray_idx;
      int dir;
      int sel;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_regs(32'd1024, 32'd153846, 32'd55968, 32'd4771);

      // every transition code, zero elapsed time, stall boundary, time wrap
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b1, 32'd0);
      offer_beat(qse_pkg::OP_TICK, 1'b0, 1'b0, 32'd0);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b1, 32'd1000);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b0, 32'd1000);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b0, 32'd3000);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b0, 32'd3500);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b1, 32'd3600);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b1, 32'd3700);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b0, 32'd3701);
      offer_beat(qse_pkg::OP_TICK, 1'b1, 1'b1, 32'd3800);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b0, 32'd4000);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b1, 32'd4100);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b0, 32'd4200);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b0, 32'd4300);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b1, 32'd4400);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b1, 32'd4500);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b0, 32'd4600);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b0, 32'd4700);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b1, 32'd4800);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b1, 32'd4900);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b1, 32'd5000);
      offer_beat(qse_pkg::OP_TICK, 1'b0, 1'b1, 32'd158846);
      offer_beat(qse_pkg::OP_TICK, 1'b1, 1'b0, 32'd158847);
      offer_beat(qse_pkg::OP_EDGE, 1'b0, 1'b0, 32'hFFFF_FFFF);
      offer_beat(qse_pkg::OP_EDGE, 1'b1, 1'b0, 32'd5);
      offer_beat(qse_pkg::OP_TICK, 1'b1, 1'b1, 32'hFFFF_FFFF);

      gray_idx = 1;
      dir = 1;
      now_us = 32'd5;
      for (int seg = 0; seg < 6; seg++) begin
         wait_all_results();
         case (seg)
            0: program_regs(32'd1024, 32'd153846, 32'd55968, 32'd4771);
            1: program_regs($urandom_range(1, 65535), $urandom_range(1000, 400000),
                            $urandom_range(0, 65535), $urandom_range(0, 65535));
            2: program_regs(32'd1, 32'hFFFF_FFFF, 32'd65535, 32'd65535);
            3: program_regs(32'd0, 32'd1, 32'd0, 32'd0);
            4: program_regs($urandom_range(1, 65535), $urandom_range(1000, 400000),
                            $urandom_range(0, 65535), $urandom_range(0, 65535));
            default: program_regs({16'($urandom_range(0, 65535)), 16'hFFFF}, $urandom(),
                                  {16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535))},
                                  {16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535))});
         endcase
         send_idle_pct <= (seg < 2) ? 9 : (seg < 4) ? 63 : 0;
         recv_idle_pct <= (seg < 2) ? 63 : (seg < 4) ? 9 : 0;
         for (int n = 0; n < SEG_BEATS; n++) begin
            if (seg >= 4 && (n == 10 || n == SEG_BEATS / 2))
               hold_asked <= hold_asked + 1;
            case ($urandom_range(19))
               0: delta = 32'd0;
               1: delta = $urandom_range(0, 400000);
               2: delta = $urandom() - now_us;
               default: delta = $urandom_range(1, 3000);
            endcase
            now_us = now_us + delta;
            noise_a = 1'($urandom_range(1));
            noise_b = 1'($urandom_range(1));
            sel = $urandom_range(99);
            if (sel < 35) begin
               offer_beat(qse_pkg::OP_TICK, noise_a, noise_b, now_us);
            end else if (sel < 90) begin
               if ($urandom_range(9) == 0) dir = -dir;
               gray_idx = (gray_idx + dir + 4) % 4;
               pins = gray_seq[gray_idx];
               offer_beat(qse_pkg::OP_EDGE, pins[1], pins[0], now_us);
            end else begin
               for (int k = 0; k < 4; k++)
                  if (gray_seq[k] == {noise_a, noise_b}) gray_idx = k;
               offer_beat(qse_pkg::OP_EDGE, noise_a, noise_b, now_us);
            end
         end
      end

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
